[hdl/ordered_array_list_defines.svh]
// Assertion macros shared by the ordered array list RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define OAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define OAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/oal_pkg.sv]
// Shared types and codes for the ordered array list.
// Used by oal_cell and ordered_array_list; depends on nothing.
`timescale 1ns / 1ps

package oal_pkg;

  localparam int unsigned KeyWidth = 32;

  typedef enum logic [2:0] {
    OP_SEARCH = 3'd0,
    OP_INSERT = 3'd1,
    OP_APPEND = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [KeyWidth-1:0] key;
    logic                apply;
  } ctrl_t;

endpackage

[hdl/ordered_array_list.sv]
// The ordered array list takes one transaction per clock cycle and presents its
// result in the following cycle, as long as the result port keeps up; the
// figure is set by one pass through the row of key cells, where every cell
// compares its key and shifts in parallel and a first-match flag ripples along
// the row. A stalled result holds in the output register while one more input
// waits at the input port. Keys are compared as exact 32-bit patterns.
`timescale 1ns / 1ps
`include "ordered_array_list_defines.svh"

module ordered_array_list #(
  parameter int CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // func [2:0], key [34:3], position [38:35], zero [39]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status [1:0], found_index [4:2], entry_count [8:5], zero [15:9]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int FI_W  = (IDX_W > 3) ? IDX_W : 3;
  localparam int EC_W  = (CNT_W > 4) ? CNT_W : 4;

  logic                         in_fire;
  oal_pkg::op_e                 op;
  logic [oal_pkg::KeyWidth-1:0] key;
  logic [3:0]                   pos;
  logic [CMP_W-1:0]             pos_ext, cnt_ext;
  oal_pkg::ctrl_t               ctrl;

  logic [CNT_W-1:0]             count_q, count_d;
  logic                         out_valid_q;
  oal_pkg::status_e             st_q, st_d;
  logic [IDX_W-1:0]             fidx_q, fidx_d;

  logic [oal_pkg::KeyWidth-1:0] ent   [CAPACITY];
  logic [CAPACITY:0]            hit;
  logic [CAPACITY-1:0]          match;
  logic                         full, any_hit, pos_ok;
  logic [IDX_W-1:0]             first_idx;
  logic [FI_W-1:0]              fidx_ext;
  logic [EC_W-1:0]              cnt_out;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = oal_pkg::op_e'(s_axis_tdata[2:0]);
  assign key           = s_axis_tdata[34:3];
  assign pos           = s_axis_tdata[38:35];
  assign pos_ext       = CMP_W'(pos);
  assign cnt_ext       = CMP_W'(count_q);

  assign full    = count_q == CNT_W'(CAPACITY);
  assign pos_ok  = pos_ext <= cnt_ext;
  assign any_hit = hit[CAPACITY];
  assign hit[0]  = 1'b0;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i] && !hit[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctrl.op    = op;
    ctrl.key   = key;
    ctrl.apply = 1'b0;
    case (op)
      oal_pkg::OP_INSERT: ctrl.apply = in_fire && !full && pos_ok;
      oal_pkg::OP_APPEND: ctrl.apply = in_fire && !full;
      oal_pkg::OP_DELETE: ctrl.apply = in_fire && any_hit;
      default:            ctrl.apply = 1'b0;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [oal_pkg::KeyWidth-1:0] left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = ent[g];
    end else begin : g_mid
      assign left_e = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = ent[g];
    end else begin : g_inner
      assign right_e = ent[g+1];
    end
    oal_cell #(
      .INDEX(g),
      .CMP_W(CMP_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (cnt_ext),
      .pos_i        (pos_ext),
      .left_entry_i (left_e),
      .right_entry_i(right_e),
      .hit_i        (hit[g]),
      .hit_o        (hit[g+1]),
      .match_o      (match[g]),
      .entry_o      (ent[g])
    );
  end

  always_comb begin
    count_d = count_q;
    st_d    = oal_pkg::ST_OK;
    fidx_d  = '0;
    case (op)
      oal_pkg::OP_SEARCH: begin
        if (any_hit) begin
          fidx_d = first_idx;
        end else begin
          st_d = oal_pkg::ST_NOTFOUND;
        end
      end
      oal_pkg::OP_INSERT: begin
        if (full) begin
          st_d = oal_pkg::ST_FULL;
        end else if (!pos_ok) begin
          st_d = oal_pkg::ST_BADPOS;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      oal_pkg::OP_APPEND: begin
        if (full) begin
          st_d = oal_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      oal_pkg::OP_DELETE: begin
        if (any_hit) begin
          fidx_d  = first_idx;
          count_d = count_q - 1'b1;
        end else begin
          st_d = oal_pkg::ST_NOTFOUND;
        end
      end
      oal_pkg::OP_CLEAR: count_d = '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_q   <= st_d;
      fidx_q <= fidx_d;
    end
  end

  assign fidx_ext      = FI_W'(fidx_q);
  assign cnt_out       = EC_W'(count_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, cnt_out[3:0], fidx_ext[2:0], st_q};

  `OAL_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `OAL_ASSERT_NEXT(a_fire_result, in_fire, out_valid_q, "accepted transaction gave no result")
  `OAL_ASSERT_NEXT(a_clear_empty, in_fire && op == oal_pkg::OP_CLEAR, count_q == '0,
                   "clear left entries behind")
  `OAL_ASSERT_NEXT(a_hit_ok, in_fire && op == oal_pkg::OP_SEARCH && any_hit,
                   st_q == oal_pkg::ST_OK, "matching search not reported as ok")

endmodule

[hdl/oal_cell.sv]
// One storage cell of the ordered array list: holds a key and takes a new one
// from itself, its neighbors or the broadcast key. Depends on oal_pkg.
`timescale 1ns / 1ps

module oal_cell #(
  parameter int INDEX = 0,
  parameter int CMP_W = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  oal_pkg::ctrl_t               ctrl_i,
  input  logic [CMP_W-1:0]             count_i,
  input  logic [CMP_W-1:0]             pos_i,
  input  logic [oal_pkg::KeyWidth-1:0] left_entry_i,
  input  logic [oal_pkg::KeyWidth-1:0] right_entry_i,
  input  logic                         hit_i,
  output logic                         hit_o,
  output logic                         match_o,
  output logic [oal_pkg::KeyWidth-1:0] entry_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(INDEX);

  logic [oal_pkg::KeyWidth-1:0] entry_q, entry_d;
  logic                         valid;

  assign valid   = MyIdx < count_i;
  assign match_o = valid && (entry_q == ctrl_i.key);
  assign hit_o   = hit_i | match_o;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.op)
        oal_pkg::OP_INSERT: begin
          if (MyIdx == pos_i) begin
            entry_d = ctrl_i.key;
          end else if (MyIdx > pos_i && MyIdx <= count_i) begin
            entry_d = left_entry_i;
          end
        end
        oal_pkg::OP_APPEND: begin
          if (MyIdx == count_i) begin
            entry_d = ctrl_i.key;
          end
        end
        oal_pkg::OP_DELETE: begin
          if (hit_o) begin
            entry_d = right_entry_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
